### src/union_find_by_size_top_macros.svh
`ifndef UNION_FIND_BY_SIZE_TOP_MACROS_SVH
`define UNION_FIND_BY_SIZE_TOP_MACROS_SVH

// Same-cycle implication, reported by label.
`define UFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reported by label.
`define UFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ufs_pkg.sv
`timescale 1ns / 1ps
package ufs_pkg;
	localparam int DEF_NODES = 1024;
	localparam int NODE_W    = 10;
	localparam int SIZE_W    = 11;
	localparam int IDX_SPAN  = 1 << NODE_W;

	typedef struct packed {
		logic              valid;
		logic              merged;
		logic [NODE_W-1:0] root;
		logic [SIZE_W-1:0] set_size;
		logic [SIZE_W-1:0] component_count;
	} result_t;
endpackage

### src/ufs_ctrl.sv
`timescale 1ns / 1ps
module ufs_ctrl #(
	parameter int NODES = ufs_pkg::DEF_NODES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ufs_pkg::NODE_W-1:0] node_a,
	input  logic [ufs_pkg::NODE_W-1:0] node_b,
	output ufs_pkg::result_t           res,
	input  logic                       res_take
);
	import ufs_pkg::*;

	localparam int DEPTH = (NODES < IDX_SPAN) ? NODES : IDX_SPAN;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(NODES + 1);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_FRD  = 4'd2;
	localparam logic [3:0] ST_FIND = 4'd3;
	localparam logic [3:0] ST_CRD  = 4'd4;
	localparam logic [3:0] ST_COMP = 4'd5;
	localparam logic [3:0] ST_SRA  = 4'd6;
	localparam logic [3:0] ST_SRB  = 4'd7;
	localparam logic [3:0] ST_SCMP = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	logic [3:0]       state_q;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W-1:0] nb_q;
	logic [IDX_W-1:0] root_q;
	logic [IDX_W-1:0] ra_q;
	logic [IDX_W-1:0] rb_q;
	logic             phase_q;
	logic [SIZE_W-1:0] sza_q;
	logic [CNT_W-1:0] comp_q;
	logic             merged_q;
	logic [IDX_W-1:0] top_q;
	logic [SIZE_W-1:0] size_q;

	logic [IDX_W-1:0] parent_mem [DEPTH];
	logic [SIZE_W-1:0] size_mem  [DEPTH];
	logic [IDX_W-1:0] p_rd_q;
	logic [SIZE_W-1:0] s_rd_q;

	logic             p_we;
	logic [IDX_W-1:0] p_raddr;
	logic [IDX_W-1:0] p_waddr;
	logic [IDX_W-1:0] p_wdata;
	logic             s_we;
	logic [IDX_W-1:0] s_raddr;
	logic [IDX_W-1:0] s_waddr;
	logic [SIZE_W-1:0] s_wdata;

	// shared compare and add unit for the link decision
	logic [SIZE_W-1:0] size_sum;
	logic              a_smaller;
	logic              in_range;
	logic [CNT_W+SIZE_W-1:0] comp_wide;

	assign size_sum  = sza_q + s_rd_q;
	assign a_smaller = sza_q < s_rd_q;
	assign in_range  = (32'(node_a) < NODES) && (32'(node_b) < NODES);
	assign comp_wide = {{SIZE_W{1'b0}}, comp_q};

	always_ff @(posedge clk) begin
		if (p_we) begin
			parent_mem[p_waddr] <= p_wdata;
		end
		p_rd_q <= parent_mem[p_raddr];
		if (s_we) begin
			size_mem[s_waddr] <= s_wdata;
		end
		s_rd_q <= size_mem[s_raddr];
	end

	always_comb begin
		p_we    = 1'b0;
		p_raddr = cur_q;
		p_waddr = cur_q;
		p_wdata = root_q;
		s_we    = 1'b0;
		s_raddr = ra_q;
		s_waddr = ra_q;
		s_wdata = size_sum;
		case (state_q)
			ST_CLR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = clr_q;
				s_we    = 1'b1;
				s_waddr = clr_q;
				s_wdata = SIZE_W'(1);
			end
			ST_FIND: begin
				p_raddr = p_rd_q;
			end
			ST_COMP: begin
				p_raddr = p_rd_q;
				p_we    = (cur_q != root_q);
			end
			ST_SRB: begin
				s_raddr = rb_q;
			end
			ST_SCMP: begin
				if (ra_q != rb_q) begin
					p_we = 1'b1;
					s_we = 1'b1;
					if (a_smaller) begin
						p_waddr = ra_q;
						p_wdata = rb_q;
						s_waddr = rb_q;
					end else begin
						p_waddr = rb_q;
						p_wdata = ra_q;
						s_waddr = ra_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			comp_q  <= CNT_W'(NODES);
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cur_q   <= node_a[IDX_W-1:0];
						start_q <= node_a[IDX_W-1:0];
						nb_q    <= node_b[IDX_W-1:0];
						phase_q <= 1'b0;
						if (in_range) begin
							state_q <= ST_FRD;
						end else begin
							merged_q <= 1'b0;
							top_q    <= '0;
							size_q   <= '0;
							state_q  <= ST_DONE;
						end
					end
				end
				ST_FRD: begin
					state_q <= ST_FIND;
				end
				ST_FIND: begin
					// follow links until a node points at itself
					if (p_rd_q == cur_q) begin
						root_q  <= cur_q;
						cur_q   <= start_q;
						state_q <= ST_CRD;
					end else begin
						cur_q <= p_rd_q;
					end
				end
				ST_CRD: begin
					state_q <= ST_COMP;
				end
				ST_COMP: begin
					if (cur_q == root_q) begin
						if (!phase_q) begin
							ra_q    <= root_q;
							cur_q   <= nb_q;
							start_q <= nb_q;
							phase_q <= 1'b1;
							state_q <= ST_FRD;
						end else begin
							rb_q    <= root_q;
							state_q <= ST_SRA;
						end
					end else begin
						cur_q <= p_rd_q;
					end
				end
				ST_SRA: begin
					state_q <= ST_SRB;
				end
				ST_SRB: begin
					sza_q   <= s_rd_q;
					state_q <= ST_SCMP;
				end
				ST_SCMP: begin
					merged_q <= (ra_q != rb_q);
					if (ra_q == rb_q) begin
						top_q  <= ra_q;
						size_q <= sza_q;
					end else begin
						top_q  <= a_smaller ? rb_q : ra_q;
						size_q <= size_sum;
						if (comp_q != '0) begin
							comp_q <= comp_q - 1'b1;
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready            = (state_q == ST_IDLE);
	assign res.valid           = (state_q == ST_DONE);
	assign res.merged          = merged_q;
	assign res.root            = NODE_W'(top_q);
	assign res.set_size        = size_q;
	assign res.component_count = comp_wide[SIZE_W-1:0];
endmodule

### src/union_find_by_size_top.sv
`timescale 1ns / 1ps
`include "union_find_by_size_top_macros.svh"
// Union-find engine, union by size with full path compression.
// Slave channel: one word is a union request naming two nodes. Master channel:
// one word per request with the merged flag, the common root, its set size
// and the running component count. A request naming a node at or above
// NODES leaves the state alone and returns zeros with the current count.
// After reset the block sweeps its parent and size memories, one entry per
// cycle, min(NODES, 1024) entries, with s_tready low; the count starts at NODES.
// An item runs, from acceptance to m_tvalid, a find walk and a compression
// walk for each of the two nodes in turn; each walk reads one link per cycle
// from the parent memory, which the compression walk reads and writes at once,
// then two size reads and one compare/add decide the link. Path compression
// keeps chains short. One item is in work at a time; the next request is
// taken only once the previous result has moved to the output register.
// The result sits in an output register; the next request is accepted while
// it waits, but the block holds its own result until the register frees up,
// so a stalled receiver eventually holds s_tready low.
module union_find_by_size_top #(
	parameter int NODES = ufs_pkg::DEF_NODES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // node_a, node_b, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // merged, root, set_size, component_count, zero pad
);
	import ufs_pkg::*;

	result_t res;
	logic    res_take;
	logic    m_tvalid_q;
	result_t out_q;

	ufs_ctrl #(
		.NODES(NODES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.node_a   (s_tdata[NODE_W-1:0]),
		.node_b   (s_tdata[2*NODE_W-1:NODE_W]),
		.res      (res),
		.res_take (res_take)
	);

	assign res_take = res.valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, out_q.component_count, out_q.set_size, out_q.root, out_q.merged};

	`UFS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "ready right after accept")
	`UFS_ASSERT_NOW(a_merge_size, clk, arst_n, m_tvalid && out_q.merged, out_q.set_size >= SIZE_W'(2), "merge gave a set below two")
	`UFS_ASSERT_NOW(a_empty_result, clk, arst_n, m_tvalid && out_q.set_size == '0, out_q.root == '0 && !out_q.merged, "zero size with a root or merge")
endmodule
